// File: rtl/mmp_pkg.sv
// ----------------------------------------------------------------------------
// mmp_pkg
// shared widths, register map and reset values for the modular multiplier
// ----------------------------------------------------------------------------
package mmp_pkg;

    localparam int LIMB_W  = 64;
    localparam int HALF_W  = LIMB_W / 2;
    localparam int WIDE_W  = 2 * LIMB_W;
    localparam int PADDR_W = 4;

    // register select is address bit 3 (registers sit 8 bytes apart)
    localparam int REG_SEL_BIT = 3;
    localparam logic REG_MODULUS    = 1'b0;
    localparam logic REG_RECIPROCAL = 1'b1;

    localparam logic [LIMB_W-1:0] MODULUS_RESET    = {1'b1, {(LIMB_W-1){1'b0}}};
    localparam logic [LIMB_W-1:0] RECIPROCAL_RESET = {LIMB_W{1'b1}};

    typedef struct packed {
        logic en;
        logic valid;
    } stage_ctl_t;

endpackage

// File: rtl/mmp_regs.sv
// ----------------------------------------------------------------------------
// mmp_regs
// apb register file holding the modulus and its precomputed reciprocal
// ----------------------------------------------------------------------------
module mmp_regs
    import mmp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [LIMB_W-1:0]  pwdata,
    output logic [LIMB_W-1:0]  prdata,
    output logic               pready,
    output logic [LIMB_W-1:0]  modulus,
    output logic [LIMB_W-1:0]  modulus_reciprocal
);

    logic [LIMB_W-1:0] modulus_reg;
    logic [LIMB_W-1:0] recip_reg;
    logic              wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg <= MODULUS_RESET;
            recip_reg   <= RECIPROCAL_RESET;
        end
        else if (wr_en)
        begin
            unique case (paddr[REG_SEL_BIT])
                REG_MODULUS:    modulus_reg <= pwdata;
                REG_RECIPROCAL: recip_reg   <= pwdata;
                default:        modulus_reg <= modulus_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[REG_SEL_BIT])
            REG_MODULUS:    prdata = modulus_reg;
            REG_RECIPROCAL: prdata = recip_reg;
            default:        prdata = '0;
        endcase
    end

    assign modulus            = modulus_reg;
    assign modulus_reciprocal = recip_reg;

endmodule

// File: rtl/mmp_wide_mul.sv
// ----------------------------------------------------------------------------
// mmp_wide_mul
// two-stage 64x64 -> 128 multiplier: half-limb partial products, then sum
// ----------------------------------------------------------------------------
module mmp_wide_mul
    import mmp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  stage_ctl_t        ctl,
    input  logic [LIMB_W-1:0] x,
    input  logic [LIMB_W-1:0] y,
    output logic              prod_valid,
    output logic [WIDE_W-1:0] prod
);

    logic [LIMB_W-1:0] ll_reg, lh_reg, hl_reg, hh_reg;
    logic [LIMB_W-1:0] ll_next, lh_next, hl_next, hh_next;
    logic [WIDE_W-1:0] prod_reg, prod_next;
    logic              pp_valid_reg, prod_valid_reg;

    always_comb
    begin
        ll_next = x[HALF_W-1:0]      * y[HALF_W-1:0];
        lh_next = x[HALF_W-1:0]      * y[LIMB_W-1:HALF_W];
        hl_next = x[LIMB_W-1:HALF_W] * y[HALF_W-1:0];
        hh_next = x[LIMB_W-1:HALF_W] * y[LIMB_W-1:HALF_W];
    end

    assign prod_next = {hh_reg, ll_reg}
                     + {{HALF_W{1'b0}}, lh_reg, {HALF_W{1'b0}}}
                     + {{HALF_W{1'b0}}, hl_reg, {HALF_W{1'b0}}};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pp_valid_reg   <= 1'b0;
            prod_valid_reg <= 1'b0;
        end
        else if (ctl.en)
        begin
            pp_valid_reg   <= ctl.valid;
            prod_valid_reg <= pp_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            ll_reg   <= ll_next;
            lh_reg   <= lh_next;
            hl_reg   <= hl_next;
            hh_reg   <= hh_next;
            prod_reg <= prod_next;
        end
    end

    assign prod_valid = prod_valid_reg;
    assign prod       = prod_reg;

endmodule

// File: rtl/mmp_reduce.sv
// ----------------------------------------------------------------------------
// mmp_reduce
// quotient estimate, multiply-subtract and two corrections, five stages
// ----------------------------------------------------------------------------
module mmp_reduce
    import mmp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  stage_ctl_t        ctl,
    input  logic [WIDE_W-1:0] est,
    input  logic [WIDE_W-1:0] prod,
    input  logic [LIMB_W-1:0] modulus,
    output logic              residue_valid,
    output logic [LIMB_W-1:0] residue
);

    localparam int DEPTH = 5;

    logic [DEPTH-1:0]  vld_reg;

    // stage 1: estimate sum and quotient
    logic [LIMB_W-1:0] sum_lo_next, q_next;
    logic              carry;
    logic [LIMB_W-1:0] s1_sum_lo_reg, s1_q_reg, s1_prod_lo_reg;

    // stage 2: low half of q * n as partial products
    logic [LIMB_W-1:0] qn_ll_next;
    logic [HALF_W-1:0] qn_lh_next, qn_hl_next;
    logic [LIMB_W-1:0] s2_ll_reg, s2_sum_lo_reg, s2_prod_lo_reg;
    logic [HALF_W-1:0] s2_lh_reg, s2_hl_reg;

    // stage 3: candidate remainder
    logic [LIMB_W-1:0] qn_lo, rem_next;
    logic [HALF_W-1:0] cross_sum;
    logic [LIMB_W-1:0] s3_rem_reg, s3_sum_lo_reg;

    // stage 4 and 5: corrections
    logic [LIMB_W-1:0] rem1_next, rem2_next;
    logic [LIMB_W-1:0] s4_rem_reg, s5_rem_reg;

    always_comb
    begin
        sum_lo_next = est[LIMB_W-1:0] + prod[LIMB_W-1:0];
        carry       = sum_lo_next < prod[LIMB_W-1:0];
        q_next      = est[WIDE_W-1:LIMB_W] + prod[WIDE_W-1:LIMB_W]
                    + {{(LIMB_W-1){1'b0}}, carry} + {{(LIMB_W-1){1'b0}}, 1'b1};
    end

    // cross terms only matter modulo 2^32
    always_comb
    begin
        qn_ll_next = s1_q_reg[HALF_W-1:0]      * modulus[HALF_W-1:0];
        qn_lh_next = s1_q_reg[HALF_W-1:0]      * modulus[LIMB_W-1:HALF_W];
        qn_hl_next = s1_q_reg[LIMB_W-1:HALF_W] * modulus[HALF_W-1:0];
    end

    always_comb
    begin
        cross_sum = s2_lh_reg + s2_hl_reg;
        qn_lo     = s2_ll_reg + {cross_sum, {HALF_W{1'b0}}};
        rem_next  = s2_prod_lo_reg - qn_lo;
    end

    assign rem1_next = (s3_rem_reg >= s3_sum_lo_reg) ? s3_rem_reg + modulus : s3_rem_reg;
    assign rem2_next = (s4_rem_reg >= modulus) ? s4_rem_reg - modulus : s4_rem_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (ctl.en)
        begin
            vld_reg <= {vld_reg[DEPTH-2:0], ctl.valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            s1_sum_lo_reg  <= sum_lo_next;
            s1_q_reg       <= q_next;
            s1_prod_lo_reg <= prod[LIMB_W-1:0];
            s2_ll_reg      <= qn_ll_next;
            s2_lh_reg      <= qn_lh_next;
            s2_hl_reg      <= qn_hl_next;
            s2_sum_lo_reg  <= s1_sum_lo_reg;
            s2_prod_lo_reg <= s1_prod_lo_reg;
            s3_rem_reg     <= rem_next;
            s3_sum_lo_reg  <= s2_sum_lo_reg;
            s4_rem_reg     <= rem1_next;
            s5_rem_reg     <= rem2_next;
        end
    end

    assign residue_valid = vld_reg[DEPTH-1];
    assign residue       = s5_rem_reg;

endmodule

// File: rtl/modular_multiply_preinverse.sv
// ----------------------------------------------------------------------------
// modular_multiply_preinverse
// 64-bit modular multiplier with a precomputed reciprocal of the modulus
// ----------------------------------------------------------------------------
// Takes one operand pair per cycle and returns multiplicand * multiplier mod
// modulus, one result per cycle. The pipeline has these stages: two for the
// operand product (half-limb partial products, then the 128-bit sum), two for
// the reciprocal product, one for the quotient estimate, one for the q * n
// partial products, one for the candidate remainder and one for each
// correction. All stages advance together; when the result waits on m_tready
// the whole pipeline holds and s_tready drops in the same cycle. Modulus
// (address 0x0, top bit set) and reciprocal (address 0x8) are to be written
// over apb only while no transaction is in flight, which the block itself does
// not enforce; operands are expected below the modulus.
module modular_multiply_preinverse
    import mmp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [LIMB_W-1:0]  pwdata,
    output logic [LIMB_W-1:0]  prdata,
    output logic               pready,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [WIDE_W-1:0]  s_tdata,   // multiplicand [63:0], multiplier [127:64]
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [LIMB_W-1:0]  m_tdata    // residue [63:0]
);

    logic              advance;
    stage_ctl_t        mul1_ctl, mul2_ctl, red_ctl;
    logic [LIMB_W-1:0] modulus, modulus_reciprocal;
    logic              prod_valid, est_valid;
    logic [WIDE_W-1:0] prod, est;
    logic [WIDE_W-1:0] prod_d1_reg, prod_d2_reg;

    mmp_regs u_regs (
        .clk                (clk),
        .rst_n              (rst_n),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready),
        .modulus            (modulus),
        .modulus_reciprocal (modulus_reciprocal)
    );

    assign advance  = m_tready || !m_tvalid;
    assign s_tready = advance;

    assign mul1_ctl = '{en: advance, valid: s_tvalid};
    assign mul2_ctl = '{en: advance, valid: prod_valid};
    assign red_ctl  = '{en: advance, valid: est_valid};

    mmp_wide_mul u_mul_op (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (mul1_ctl),
        .x          (s_tdata[LIMB_W-1:0]),
        .y          (s_tdata[WIDE_W-1:LIMB_W]),
        .prod_valid (prod_valid),
        .prod       (prod)
    );

    mmp_wide_mul u_mul_recip (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (mul2_ctl),
        .x          (modulus_reciprocal),
        .y          (prod[WIDE_W-1:LIMB_W]),
        .prod_valid (est_valid),
        .prod       (est)
    );

    // operand product delayed to line up with the reciprocal product
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            prod_d1_reg <= prod;
            prod_d2_reg <= prod_d1_reg;
        end
    end

    mmp_reduce u_reduce (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (red_ctl),
        .est           (est),
        .prod          (prod_d2_reg),
        .modulus       (modulus),
        .residue_valid (m_tvalid),
        .residue       (m_tdata)
    );

    property p_ready_only_when_output_free;
        @(posedge clk) disable iff (!rst_n)
        (s_tready && !m_tready) |-> !m_tvalid;
    endproperty
    a_ready_only_when_output_free: assert property (p_ready_only_when_output_free)
        else $error("input ready while a result is stalled");

    property p_modulus_write;
        @(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && (paddr[REG_SEL_BIT] == REG_MODULUS))
            |=> (modulus == $past(pwdata));
    endproperty
    a_modulus_write: assert property (p_modulus_write)
        else $error("modulus register not updated by write");

    property p_stall_holds_valid;
        @(posedge clk) disable iff (!rst_n)
        (!advance && est_valid) |=> est_valid;
    endproperty
    a_stall_holds_valid: assert property (p_stall_holds_valid)
        else $error("in-flight transaction lost during stall");

endmodule

// File: tb/tb_modular_multiply_preinverse.sv
// ----------------------------------------------------------------------------
// tb_modular_multiply_preinverse
// streaming testbench for the 64-bit modular multiplier with a precomputed
// reciprocal. Operand pairs go out from a queue through a clocked driver.
// Each accepted pair is reduced by a local predictor, and the monitor checks
// every result against it in order. Modulus and reciprocal are written over
// apb between phases: matched and unmatched pairs, normalized and
// unnormalized moduli, and the extreme values of both registers. Both sides
// idle at random, and one long receiver hold-off fills the pipeline.
// ----------------------------------------------------------------------------
module tb_modular_multiply_preinverse;
    import mmp_pkg::*;

    localparam int LATENCY       = 9;
    localparam int STALL_CYCLES  = 400;
    localparam int MAX_REPORTS   = 10;
    localparam int SEND_IDLE_PCT = 25;
    localparam int RECV_IDLE_PCT = 77;
    localparam logic [PADDR_W-1:0] ADDR_MODULUS    = PADDR_W'(REG_MODULUS) << REG_SEL_BIT;
    localparam logic [PADDR_W-1:0] ADDR_RECIPROCAL = PADDR_W'(REG_RECIPROCAL) << REG_SEL_BIT;
    localparam logic [LIMB_W-1:0]  ALL_ONES        = {LIMB_W{1'b1}};

    logic              clk      = 1'b0;
    logic              rst_n    = 1'b0;
    logic              psel     = 1'b0;
    logic              penable  = 1'b0;
    logic              pwrite   = 1'b0;
    logic [PADDR_W-1:0] paddr   = '0;
    logic [LIMB_W-1:0] pwdata   = '0;
    logic [LIMB_W-1:0] prdata;
    logic              pready;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [WIDE_W-1:0] s_tdata  = '0;   // multiplicand [63:0], multiplier [127:64]
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [LIMB_W-1:0] m_tdata;         // residue [63:0]

    logic [WIDE_W-1:0] operand_q[$];
    logic [LIMB_W-1:0] residue_q[$];
    logic [LIMB_W-1:0] modulus_cfg    = MODULUS_RESET;
    logic [LIMB_W-1:0] reciprocal_cfg = RECIPROCAL_RESET;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int accepted_count = 0;
    int stall_trigger = -1;
    int stall_left = 0;
    int err_count = 0;

    modular_multiply_preinverse uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 clk = ~clk;

    function automatic logic [LIMB_W-1:0] predict_residue(input logic [LIMB_W-1:0] a,
                                                          input logic [LIMB_W-1:0] b,
                                                          input logic [LIMB_W-1:0] n,
                                                          input logic [LIMB_W-1:0] r);
        logic [WIDE_W-1:0] prod;
        logic [WIDE_W-1:0] est;
        logic [LIMB_W-1:0] quot;
        logic [LIMB_W-1:0] sum_lo;
        logic [LIMB_W-1:0] rem;
        prod   = {{LIMB_W{1'b0}}, a} * {{LIMB_W{1'b0}}, b};
        est    = {{LIMB_W{1'b0}}, r} * {{LIMB_W{1'b0}}, prod[WIDE_W-1:LIMB_W]} + prod;
        quot   = est[WIDE_W-1:LIMB_W] + 64'd1;
        sum_lo = est[LIMB_W-1:0];
        rem    = prod[LIMB_W-1:0] - quot * n;
        if (rem >= sum_lo)
            rem = rem + n;
        if (rem >= n)
            rem = rem - n;
        return rem;
    endfunction

    function automatic logic [LIMB_W-1:0] calc_reciprocal(input logic [LIMB_W-1:0] n);
        logic [WIDE_W-1:0] q;
        q = {WIDE_W{1'b1}} / {{LIMB_W{1'b0}}, n};
        return q[LIMB_W-1:0];
    endfunction

    function automatic logic [LIMB_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [LIMB_W-1:0] pick_operand(input logic [LIMB_W-1:0] n);
        int sel;
        sel = $urandom_range(15);
        case (sel)
            0: return '0;
            1: return n - 64'd1;
            2: return ALL_ONES;
            3: return 64'd1;
            4, 5: return rand64();
            default: return rand64() % n;
        endcase
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                residue_q.push_back(predict_residue(s_tdata[LIMB_W-1:0], s_tdata[WIDE_W-1:LIMB_W],
                                                    modulus_cfg, reciprocal_cfg));
                accepted_count <= accepted_count + 1;
            end
            if (!s_tvalid || s_tready)
            begin
                if (operand_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    s_tdata  <= operand_q.pop_front();
                    s_tvalid <= 1'b1;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off once the trigger transaction is accepted
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stall_left <= 0;
        else if (stall_left != 0)
            stall_left <= stall_left - 1;
        else if (s_tvalid && s_tready && accepted_count == stall_trigger)
            stall_left <= STALL_CYCLES;
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        logic [LIMB_W-1:0] want;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (residue_q.size() == 0)
                begin
                    if (err_count < MAX_REPORTS)
                        $display("unexpected residue transaction: got %h", m_tdata);
                    err_count <= err_count + 1;
                end
                else
                begin
                    want = residue_q.pop_front();
                    if (m_tdata !== want)
                    begin
                        if (err_count < MAX_REPORTS)
                            $display("residue mismatch: expected %h got %h", want, m_tdata);
                        err_count <= err_count + 1;
                    end
                end
            end
            m_tready <= (stall_left == 0) && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [LIMB_W-1:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic write_config(input logic [LIMB_W-1:0] n, input logic [LIMB_W-1:0] r);
        apb_write(ADDR_MODULUS, n);
        modulus_cfg = n;
        apb_write(ADDR_RECIPROCAL, r);
        reciprocal_cfg = r;
    endtask

    task automatic push_pair(input logic [LIMB_W-1:0] a, input logic [LIMB_W-1:0] b);
        operand_q.push_back({b, a});
    endtask

    task automatic push_random(input int count);
        for (int i = 0; i < count; i++)
            push_pair(pick_operand(modulus_cfg), pick_operand(modulus_cfg));
    endtask

    // sample on the falling edge so driver and monitor updates have settled
    task automatic wait_drain();
        while (operand_q.size() != 0 || s_tvalid || residue_q.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 2) @(posedge clk);
    endtask

    task automatic set_idle(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
    endtask

    initial
    begin
        logic [LIMB_W-1:0] n_val;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset register values
        set_idle(SEND_IDLE_PCT, RECV_IDLE_PCT);
        n_val = MODULUS_RESET;
        push_pair('0, '0);
        push_pair('0, ALL_ONES);
        push_pair(ALL_ONES, '0);
        push_pair(ALL_ONES, ALL_ONES);
        push_pair(64'd1, 64'd1);
        push_pair(n_val - 64'd1, n_val - 64'd1);
        push_pair(n_val - 64'd1, 64'd1);
        push_pair(64'd1, n_val - 64'd1);
        push_pair(n_val, n_val);
        push_pair(n_val - 64'd1, 64'd2);
        push_pair(64'h0000_0000_FFFF_FFFF, 64'h0000_0000_FFFF_FFFF);
        push_pair(64'hFFFF_FFFF_0000_0000, 64'h0000_0000_FFFF_FFFF);
        push_pair(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
        push_pair(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
        wait_drain();

        // largest modulus
        n_val = ALL_ONES;
        write_config(n_val, calc_reciprocal(n_val));
        push_pair(n_val - 64'd1, n_val - 64'd1);
        push_pair(n_val - 64'd1, 64'd1);
        push_pair(n_val, n_val);
        push_pair(64'h8000_0000_0000_0000, 64'd2);
        push_pair(64'h0000_0001_0000_0000, 64'h0000_0001_0000_0000);
        push_random(250);
        wait_drain();

        set_idle(RECV_IDLE_PCT, SEND_IDLE_PCT);
        n_val = rand64() | MODULUS_RESET;
        write_config(n_val, calc_reciprocal(n_val));
        push_random(250);
        wait_drain();

        n_val = MODULUS_RESET | 64'($urandom_range(65535));
        write_config(n_val, calc_reciprocal(n_val));
        push_random(250);
        wait_drain();

        // unnormalized modulus, smallest reciprocal
        set_idle(0, 0);
        n_val = (rand64() & ~MODULUS_RESET) | 64'd1;
        write_config(n_val, '0);
        push_random(150);
        wait_drain();

        // normalized modulus with an unrelated reciprocal
        write_config(rand64() | MODULUS_RESET, rand64());
        push_random(100);
        wait_drain();

        // smallest normalized modulus written back, receiver hold-off in the middle
        write_config(MODULUS_RESET, calc_reciprocal(MODULUS_RESET));
        stall_trigger = accepted_count + 40;
        push_random(300);
        wait_drain();

        repeat (2 * LATENCY) @(posedge clk);
        if (err_count == 0 && residue_q.size() == 0)
            $display("[modular_multiply_preinverse] OK");
        else
            $display("[modular_multiply_preinverse] ERROR");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("[modular_multiply_preinverse] ERROR");
        $finish;
    end

endmodule
